>>> hdl/fss_pkg.sv
// Package with the constants and helper functions of the fuzzy subsequence scorer.
package fss_pkg;

  // Sizes of the query store and the text length counter.
  localparam int unsigned MAX_QUERY    = 32;
  localparam int unsigned MAX_TEXT_LEN = 4095;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned QLEN_W   = 6;
  localparam int unsigned QPOS_W   = $clog2(MAX_QUERY + 1);
  localparam int unsigned QIDX_W   = 5;
  localparam int unsigned CHUNK_W  = 64;
  localparam int unsigned NCHUNKS  = 4;
  localparam int unsigned LEN_W    = $clog2(MAX_TEXT_LEN + 1);
  localparam int unsigned SCORE_W  = 10;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LENGTH  = 3'd0,
    CFG_QUERY_CHARS_0 = 3'd1,
    CFG_QUERY_CHARS_1 = 3'd2,
    CFG_QUERY_CHARS_2 = 3'd3,
    CFG_QUERY_CHARS_3 = 3'd4
  } cfg_index_e;

  // Score contributions.
  localparam logic [SCORE_W-1:0] GAIN_MATCH    = SCORE_W'(10);
  localparam logic [SCORE_W-1:0] GAIN_ADJACENT = SCORE_W'(5);
  localparam logic [SCORE_W-1:0] GAIN_BOUNDARY = SCORE_W'(3);
  localparam logic [SCORE_W-1:0] GAIN_BASENAME = SCORE_W'(20);
  localparam logic [SCORE_W-1:0] SCORE_FLOOR   = SCORE_W'(1);
  localparam int unsigned        LEN_SHIFT     = 3;

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DASH       = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

  // Folds an ASCII capital letter to lower case.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

>>> hdl/fuzzy_subsequence_scorer.sv
// Top level of the fuzzy subsequence scorer: query store, per-text state and result register.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i,     | in
//           | cfg_data_i                                |
//  text     | in_valid_i, in_ready_o, text_char_i,       | in
//           | text_last_i                               |
//  result   | out_valid_o, out_ready_i, score_o,         | out
//           | matched_o                                 |
//
// One text character is taken every cycle while in_ready_o is high; the running match state updates in the same cycle.
// The score appears in the result register in the cycle after the transfer of the last character.
// The text input stalls only while a result waits and out_ready_i is low.
// The reset clears the query and the per-text state; no clearing pass.
module fuzzy_subsequence_scorer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fss_pkg::CHUNK_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fss_pkg::CHAR_W-1:0]   text_char_i,
  input  logic                         text_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fss_pkg::SCORE_W-1:0]  score_o,
  output logic                         matched_o
);
  import fss_pkg::*;

  localparam int unsigned SUB_W = (LEN_W > SCORE_W) ? LEN_W : SCORE_W;

  // Configuration registers.
  logic [QLEN_W-1:0]               qlen_cfg_q;
  logic [NCHUNKS-1:0][CHUNK_W-1:0] qchars_q;

  // Per-text state.
  logic [QPOS_W-1:0]  qpos_q, qpos_d;
  logic [QPOS_W-1:0]  bpos_q, bpos_d;
  logic               prev_match_q, prev_match_d;
  logic               prev_bound_q, prev_bound_d;
  logic [SCORE_W-1:0] accum_q, accum_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               slash_q, slash_d;

  // Result register.
  logic               out_valid_q;
  logic [SCORE_W-1:0] score_q, score_d;
  logic               matched_q, matched_d;

  logic               in_xfer;
  logic [QPOS_W-1:0]  qlen;
  logic [CHAR_W-1:0]  c_fold;
  logic [CHAR_W-1:0]  q_char;
  logic [CHAR_W-1:0]  b_char;
  logic               hit;
  logic               is_slash;
  logic [SCORE_W-1:0] gain;
  logic [SUB_W-1:0]   accum_ext;
  logic [SUB_W-1:0]   len_div_ext;
  logic [SCORE_W-1:0] base_score;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_cfg_q <= '0;
      qchars_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_QUERY_LENGTH:  qlen_cfg_q  <= cfg_data_i[QLEN_W-1:0];
        CFG_QUERY_CHARS_0: qchars_q[0] <= cfg_data_i;
        CFG_QUERY_CHARS_1: qchars_q[1] <= cfg_data_i;
        CFG_QUERY_CHARS_2: qchars_q[2] <= cfg_data_i;
        CFG_QUERY_CHARS_3: qchars_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective query length, limited to the size of the query store.
  always_comb begin
    if (32'(qlen_cfg_q) > MAX_QUERY) begin
      qlen = QPOS_W'(MAX_QUERY);
    end else begin
      qlen = QPOS_W'(qlen_cfg_q);
    end
  end

  // Query characters at the two match pointers; positions wrap at the store size.
  assign q_char = fold_case(qchars_q[qpos_q[QIDX_W-1:3]][{qpos_q[2:0], 3'b000} +: CHAR_W]);
  assign b_char = fold_case(qchars_q[bpos_q[QIDX_W-1:3]][{bpos_q[2:0], 3'b000} +: CHAR_W]);
  assign c_fold = fold_case(text_char_i);

  // Next per-text state for the character under transfer.
  always_comb begin
    is_slash = (text_char_i == CH_SLASH);
    hit      = (qpos_q < qlen) && (c_fold == q_char);

    gain = GAIN_MATCH;
    if (prev_match_q) begin
      gain = gain + GAIN_ADJACENT;
    end
    if (prev_bound_q) begin
      gain = gain + GAIN_BOUNDARY;
    end

    accum_d = accum_q;
    qpos_d  = qpos_q;
    if (hit) begin
      accum_d = accum_q + gain;
      qpos_d  = qpos_q + QPOS_W'(1);
    end

    bpos_d  = bpos_q;
    slash_d = slash_q;
    if (is_slash) begin
      slash_d = 1'b1;
      bpos_d  = '0;
    end else if ((bpos_q < qlen) && (c_fold == b_char)) begin
      bpos_d = bpos_q + QPOS_W'(1);
    end

    prev_match_d = hit;
    prev_bound_d = (text_char_i inside {CH_SLASH, CH_UNDERSCORE, CH_DASH, CH_DOT});

    len_d = len_q;
    if (32'(len_q) < MAX_TEXT_LEN) begin
      len_d = len_q + LEN_W'(1);
    end
  end

  // Final score from the updated state, used only on the last character.
  always_comb begin
    accum_ext   = SUB_W'(accum_d);
    len_div_ext = SUB_W'(len_d >> LEN_SHIFT);
    if (accum_ext > len_div_ext) begin
      base_score = SCORE_W'(accum_ext - len_div_ext);
    end else begin
      base_score = SCORE_FLOOR;
    end

    matched_d = (qpos_d >= qlen);
    score_d   = '0;
    if (matched_d) begin
      score_d = base_score;
      if (slash_d && (bpos_d >= qlen)) begin
        score_d = base_score + GAIN_BASENAME;
      end
    end
  end

  // Per-text state register; it returns to the start-of-text values after the last character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q       <= '0;
      bpos_q       <= '0;
      prev_match_q <= 1'b0;
      prev_bound_q <= 1'b1;
      accum_q      <= '0;
      len_q        <= '0;
      slash_q      <= 1'b0;
    end else if (in_xfer) begin
      if (text_last_i) begin
        qpos_q       <= '0;
        bpos_q       <= '0;
        prev_match_q <= 1'b0;
        prev_bound_q <= 1'b1;
        accum_q      <= '0;
        len_q        <= '0;
        slash_q      <= 1'b0;
      end else begin
        qpos_q       <= qpos_d;
        bpos_q       <= bpos_d;
        prev_match_q <= prev_match_d;
        prev_bound_q <= prev_bound_d;
        accum_q      <= accum_d;
        len_q        <= len_d;
        slash_q      <= slash_d;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && text_last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer && text_last_i) begin
      score_q   <= score_d;
      matched_q <= matched_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign matched_o   = matched_q;

endmodule
